// ----- hw/rtl/ucct_pkg.sv -----
// Types and constants shared by the client connection tracker.
// No dependencies.
`timescale 1ns / 1ps
package ucct_pkg;
  localparam logic [2:0] CMD_CONNECT = 3'd0;
  localparam logic [2:0] CMD_STATE = 3'd1;
  localparam logic [2:0] CMD_RELIABLE = 3'd2;
  localparam logic [2:0] CMD_DISCONNECT = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd5;

  localparam logic [2:0] K_REJECT = 3'd0;
  localparam logic [2:0] K_CONNECTED = 3'd1;
  localparam logic [2:0] K_STATE = 3'd2;
  localparam logic [2:0] K_RANGE = 3'd3;
  localparam logic [2:0] K_DISCONNECTED = 3'd4;
  localparam logic [2:0] K_SEND_DISC = 3'd5;
  localparam logic [2:0] K_SEND_ACCEPT = 3'd6;
  localparam logic [2:0] K_SEND_STATE = 3'd7;

  localparam logic [1:0] LS_ACCEPTING = 2'd0;
  localparam logic [1:0] LS_CONNECTED = 2'd1;
  localparam logic [1:0] LS_DISCONNECTING = 2'd2;

  localparam logic [7:0] NO_CLIENT = 8'd255;

  // config register indexes
  localparam logic CFG_MAX_CLIENTS = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_DECIDE, ST_EMIT1, ST_EMIT2, ST_WAIT1, ST_WAIT2,
    ST_TREAD, ST_TDECIDE, ST_TEMIT1, ST_TEMIT2
  } state_t;

  typedef struct packed {
    logic load;       // capture input beat
    logic scan_start; // start slot search at 0
    logic scan_step;  // advance slot pointer
    logic apply;      // write packet update to slot
    logic tick_apply; // write tick update to slot
    logic emit1;      // load first result
    logic emit2;      // load second result
    logic mark_last;  // result being loaded ends the item
    logic tick_end;   // bump server_seq
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic has1;
    logic has2;
    logic t_has2;
    logic t_emit;
    logic is_tick;
    logic out_busy;
    logic last_slot;
    logic final_slot; // no occupied slot above the walk pointer
  } sts_t;
endpackage

// ----- hw/rtl/udp_client_connection_tracker.sv -----
// Top level of the client connection tracker: config registers, sequencer, datapath.
// Depends on ucct_pkg, ucct_ctrl, ucct_datapath.
`timescale 1ns / 1ps
// A packet header is handled by a one-slot-per-cycle search of the table, then a
// decide state, then one result state per result; a tick runs the search pass, a
// restart state and a one-slot-per-cycle walk, held by output stalls, with an extra
// emit state for each client that times out while not disconnecting. Output stalls
// also hold the result states. One item is processed at a time; the
// result register lets the last result wait while the next item is taken. tlast
// marks the final result of each item; on a tick that is the result of the
// highest occupied slot.
module udp_client_connection_tracker #(
  parameter int MAX_CLIENTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[2:0], peer_addr[34:3], peer_port[50:35], seq_index[82:51],
  // echo_stamp[114:83], acked_reliable[146:115], msg_count[162:147], zero pad
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kind[2:0], client_id[10:3], dest_addr[42:11], dest_port[58:43],
  // index_first[90:59], index_last[122:91], rtt_ticks[138:123], zero pad
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  logic [4:0]  max_clients;
  logic [15:0] timeout_ticks;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_clients <= 5'd16; timeout_ticks <= 16'd60;
    end else if (cfg_valid) begin
      if (cfg_index == ucct_pkg::CFG_MAX_CLIENTS) max_clients <= cfg_data[4:0];
      else timeout_ticks <= cfg_data;
    end
  end

  ucct_pkg::cmd_t ctl;
  ucct_pkg::sts_t sts;

  ucct_ctrl u_ctrl (.clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts, .ctl);

  logic [2:0] k; logic [7:0] id; logic [31:0] a, f, l; logic [15:0] p, r;
  ucct_datapath #(.MAX_CLIENTS(MAX_CLIENTS)) u_dp (
    .clk, .rst, .ctl, .sts,
    .in_cmd(s_axis_tdata[2:0]), .in_addr(s_axis_tdata[34:3]),
    .in_port(s_axis_tdata[50:35]), .in_seq(s_axis_tdata[82:51]),
    .in_echo(s_axis_tdata[114:83]), .in_acked(s_axis_tdata[146:115]),
    .in_cnt(s_axis_tdata[162:147]), .max_clients, .timeout_ticks,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .o_kind(k), .o_id(id), .o_addr(a), .o_port(p), .o_first(f), .o_last_idx(l),
    .o_rtt(r), .o_last(m_axis_tlast));
  assign m_axis_tdata = {5'd0, r, l, f, p, a, id, k};
endmodule

// ----- hw/rtl/ucct_datapath.sv -----
// Slot table, arithmetic and result register of the tracker.
// Depends on ucct_pkg.
`timescale 1ns / 1ps
module ucct_datapath #(
  parameter int MAX_CLIENTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  ucct_pkg::cmd_t  ctl,
  output ucct_pkg::sts_t  sts,
  input  logic [2:0]      in_cmd,
  input  logic [31:0]     in_addr,
  input  logic [15:0]     in_port,
  input  logic [31:0]     in_seq,
  input  logic [31:0]     in_echo,
  input  logic [31:0]     in_acked,
  input  logic [15:0]     in_cnt,
  input  logic [4:0]      max_clients,
  input  logic [15:0]     timeout_ticks,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      o_kind,
  output logic [7:0]      o_id,
  output logic [31:0]     o_addr,
  output logic [15:0]     o_port,
  output logic [31:0]     o_first,
  output logic [31:0]     o_last_idx,
  output logic [15:0]     o_rtt,
  output logic            o_last
);
  localparam int SW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CW = $clog2(MAX_CLIENTS + 1);

  logic [MAX_CLIENTS-1:0] slot_valid;
  logic [1:0]  link_state [MAX_CLIENTS];
  logic [31:0] slot_addr [MAX_CLIENTS];
  logic [15:0] slot_port [MAX_CLIENTS];
  logic [15:0] idle_ticks [MAX_CLIENTS];
  logic [31:0] client_seq [MAX_CLIENTS];
  logic [15:0] client_rtt [MAX_CLIENTS];
  logic [31:0] latest_reliable [MAX_CLIENTS];
  logic [31:0] server_seq, now_ticks;

  logic [2:0]  r_cmd;
  logic [31:0] r_addr, r_seq, r_echo, r_acked;
  logic [15:0] r_port, r_cnt;

  logic [SW:0] ptr;
  logic [SW-1:0] sp;
  logic        found;
  logic [SW-1:0] hit;
  logic [CW-1:0] used;
  logic        has_free;
  logic [SW-1:0] free_s;

  assign sp = ptr[SW-1:0];

  // match and occupancy per slot, visited one per cycle
  logic match_here;
  assign match_here = slot_valid[sp] && slot_addr[sp] == r_addr && slot_port[sp] == r_port;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r_cmd <= in_cmd; r_addr <= in_addr; r_port <= in_port; r_seq <= in_seq;
      r_echo <= in_echo; r_acked <= in_acked; r_cnt <= in_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0; found <= 1'b0; hit <= '0; used <= '0; has_free <= 1'b0; free_s <= '0;
    end else if (ctl.scan_start) begin
      ptr <= '0; found <= 1'b0; used <= '0; has_free <= 1'b0;
    end else if (ctl.scan_step) begin
      ptr <= ptr + (SW+1)'(1);
      if (r_cmd != ucct_pkg::CMD_TICK) begin
        if (match_here && !found) begin
          found <= 1'b1; hit <= sp;
        end
        if (slot_valid[sp]) used <= used + CW'(1);
        else if (!has_free) begin
          has_free <= 1'b1; free_s <= sp;
        end
      end
    end
  end

  // per-command decision on the found slot
  logic [SW-1:0] s;
  assign s = (r_cmd == ucct_pkg::CMD_TICK) ? sp : hit;
  logic [4:0]  cap;
  assign cap = (32'(max_clients) < MAX_CLIENTS) ? max_clients : 5'(MAX_CLIENTS);
  logic [31:0] rtt_raw, last_idx, prev_p1, first_idx;
  logic [15:0] rtt_sat;
  assign rtt_raw = now_ticks - r_echo;
  assign rtt_sat = (rtt_raw > 32'(timeout_ticks)) ? timeout_ticks : rtt_raw[15:0];
  assign last_idx = r_seq + 32'(r_cnt) - 32'd1;
  assign prev_p1 = latest_reliable[s] + 32'd1;
  assign first_idx = (prev_p1 > r_seq) ? prev_p1 : r_seq;

  logic st_ok, st_promote, st_new, rel_take, rel_emit, disc_ok, conn_rej, conn_take;
  assign st_ok = found && link_state[s] != ucct_pkg::LS_DISCONNECTING;
  assign st_promote = st_ok && link_state[s] == ucct_pkg::LS_ACCEPTING;
  assign st_new = st_ok && client_seq[s] < r_seq;
  assign rel_take = found && link_state[s] == ucct_pkg::LS_CONNECTED &&
                    last_idx > latest_reliable[s];
  assign rel_emit = rel_take && r_cnt != 16'd0 && first_idx <= last_idx;
  assign disc_ok = st_ok;
  assign conn_rej = !found && (32'(used) >= 32'(cap) || !has_free);
  assign conn_take = !found && !conn_rej;

  // tick view of the current slot
  logic [15:0] idle_inc;
  logic t_drop;
  assign idle_inc = (idle_ticks[sp] != 16'hFFFF) ? idle_ticks[sp] + 16'd1 : idle_ticks[sp];
  assign t_drop = idle_inc >= timeout_ticks;

  // occupancy from the walk pointer up; slots above it are untouched so far
  logic [MAX_CLIENTS-1:0] upper;
  assign upper = slot_valid >> sp;

  always_comb begin
    sts.scan_done = 32'(ptr) == MAX_CLIENTS - 1;
    sts.found = found;
    sts.is_tick = r_cmd == ucct_pkg::CMD_TICK;
    sts.out_busy = out_valid && !out_ready;
    sts.last_slot = 32'(ptr) == MAX_CLIENTS - 1;
    sts.final_slot = (upper >> 1) == '0;
    sts.t_emit = slot_valid[sp];
    sts.t_has2 = t_drop && link_state[sp] != ucct_pkg::LS_DISCONNECTING;
    sts.has1 = 1'b0; sts.has2 = 1'b0;
    case (r_cmd)
      ucct_pkg::CMD_CONNECT: sts.has1 = conn_rej;
      ucct_pkg::CMD_STATE: begin
        sts.has1 = st_promote || st_new; sts.has2 = st_promote && st_new;
      end
      ucct_pkg::CMD_RELIABLE: sts.has1 = rel_emit;
      ucct_pkg::CMD_DISCONNECT: sts.has1 = disc_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0; server_seq <= '0; now_ticks <= '0;
    end else begin
      if (ctl.load && in_cmd == ucct_pkg::CMD_TICK) now_ticks <= now_ticks + 32'd1;
      if (ctl.tick_end) server_seq <= server_seq + 32'd1;
      if (ctl.apply) begin
        case (r_cmd)
          ucct_pkg::CMD_CONNECT: if (conn_take) begin
            slot_valid[free_s] <= 1'b1; slot_addr[free_s] <= r_addr;
            slot_port[free_s] <= r_port; link_state[free_s] <= ucct_pkg::LS_ACCEPTING;
            idle_ticks[free_s] <= '0; client_seq[free_s] <= '0;
            client_rtt[free_s] <= '0; latest_reliable[free_s] <= '0;
          end
          ucct_pkg::CMD_STATE: begin
            if (st_promote) link_state[s] <= ucct_pkg::LS_CONNECTED;
            if (st_new) begin
              client_seq[s] <= r_seq; client_rtt[s] <= rtt_sat; idle_ticks[s] <= '0;
            end
          end
          ucct_pkg::CMD_RELIABLE: if (rel_take) latest_reliable[s] <= last_idx;
          ucct_pkg::CMD_DISCONNECT: if (disc_ok) begin
            link_state[s] <= ucct_pkg::LS_DISCONNECTING; idle_ticks[s] <= '0;
          end
          default: ;
        endcase
      end
      if (ctl.tick_apply && slot_valid[sp]) begin
        idle_ticks[sp] <= idle_inc;
        if (t_drop) slot_valid[sp] <= 1'b0;
      end
    end
  end

  // result register
  logic [2:0] k1;
  always_comb begin
    k1 = ucct_pkg::K_REJECT;
    if (sts.is_tick) begin
      if (t_drop || link_state[sp] == ucct_pkg::LS_DISCONNECTING) k1 = ucct_pkg::K_SEND_DISC;
      else if (link_state[sp] == ucct_pkg::LS_ACCEPTING) k1 = ucct_pkg::K_SEND_ACCEPT;
      else k1 = ucct_pkg::K_SEND_STATE;
    end else begin
      case (r_cmd)
        ucct_pkg::CMD_STATE: k1 = st_promote ? ucct_pkg::K_CONNECTED : ucct_pkg::K_STATE;
        ucct_pkg::CMD_RELIABLE: k1 = ucct_pkg::K_RANGE;
        ucct_pkg::CMD_DISCONNECT: k1 = ucct_pkg::K_DISCONNECTED;
        default: k1 = ucct_pkg::K_REJECT;
      endcase
    end
  end

  logic [2:0] kk;
  assign kk = ctl.emit2 ? (sts.is_tick ? ucct_pkg::K_DISCONNECTED : ucct_pkg::K_STATE) : k1;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.emit1 || ctl.emit2) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.emit1 || ctl.emit2) begin
      o_kind <= kk; o_last <= ctl.mark_last;
      o_first <= '0; o_last_idx <= '0; o_rtt <= '0;
      if (kk == ucct_pkg::K_REJECT) begin
        o_id <= ucct_pkg::NO_CLIENT; o_addr <= r_addr; o_port <= r_port;
      end else begin
        o_id <= 8'(s); o_addr <= slot_addr[s]; o_port <= slot_port[s];
      end
      case (kk)
        ucct_pkg::K_STATE: begin
          o_first <= r_acked; o_last_idx <= latest_reliable[s]; o_rtt <= rtt_sat;
        end
        ucct_pkg::K_RANGE: begin
          o_first <= first_idx; o_last_idx <= last_idx;
        end
        ucct_pkg::K_SEND_STATE: begin
          o_first <= server_seq; o_last_idx <= latest_reliable[s]; o_rtt <= client_rtt[s];
        end
        default: ;
      endcase
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit1 || ctl.emit2) |-> !(out_valid && !out_ready))
    else $error("result overwritten");
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(ctl.apply && ctl.tick_apply)) else $error("two slot writers");
  a_used: assert property (@(posedge clk) disable iff (rst)
    32'(used) <= MAX_CLIENTS) else $error("count overflow");
endmodule

// ----- hw/rtl/ucct_ctrl.sv -----
// Sequencer of the tracker: search, decide, emit, tick walk.
// Depends on ucct_pkg.
`timescale 1ns / 1ps
module ucct_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ucct_pkg::sts_t sts,
  output ucct_pkg::cmd_t ctl
);
  ucct_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ucct_pkg::ST_IDLE;
    else state <= state_next;
  end

  // tick: state after one slot is done
  ucct_pkg::state_t t_after;
  assign t_after = sts.last_slot ? ucct_pkg::ST_IDLE : ucct_pkg::ST_TDECIDE;

  always_comb begin
    state_next = state;
    case (state)
      ucct_pkg::ST_IDLE: if (in_valid) state_next = ucct_pkg::ST_SEARCH;
      ucct_pkg::ST_SEARCH: if (sts.scan_done)
        state_next = sts.is_tick ? ucct_pkg::ST_TREAD : ucct_pkg::ST_DECIDE;
      ucct_pkg::ST_DECIDE:
        if (!sts.has1) state_next = ucct_pkg::ST_IDLE;
        else state_next = ucct_pkg::ST_WAIT1;
      ucct_pkg::ST_WAIT1: if (!sts.out_busy)
        state_next = sts.has2 ? ucct_pkg::ST_WAIT2 : ucct_pkg::ST_IDLE;
      ucct_pkg::ST_WAIT2: if (!sts.out_busy) state_next = ucct_pkg::ST_IDLE;
      ucct_pkg::ST_TREAD: state_next = ucct_pkg::ST_TDECIDE;
      ucct_pkg::ST_TDECIDE:
        if (!sts.t_emit) state_next = t_after;
        else if (!sts.out_busy)
          state_next = sts.t_has2 ? ucct_pkg::ST_TEMIT2 : t_after;
      ucct_pkg::ST_TEMIT2: if (!sts.out_busy) state_next = t_after;
      default: state_next = ucct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = state == ucct_pkg::ST_IDLE;
    case (state)
      ucct_pkg::ST_IDLE: if (in_valid) begin
        ctl.load = 1'b1; ctl.scan_start = 1'b1;
      end
      ucct_pkg::ST_SEARCH: ctl.scan_step = 1'b1;
      ucct_pkg::ST_DECIDE: if (!sts.has1) ctl.apply = 1'b1;
      ucct_pkg::ST_WAIT1: if (!sts.out_busy) begin
        ctl.emit1 = 1'b1; ctl.mark_last = !sts.has2;
        if (!sts.has2) ctl.apply = 1'b1;
      end
      ucct_pkg::ST_WAIT2: if (!sts.out_busy) begin
        ctl.emit2 = 1'b1; ctl.mark_last = 1'b1; ctl.apply = 1'b1;
      end
      ucct_pkg::ST_TREAD: ctl.scan_start = 1'b1;
      ucct_pkg::ST_TDECIDE:
        if (!sts.t_emit) begin
          ctl.scan_step = !sts.last_slot; ctl.tick_end = sts.last_slot;
        end else if (!sts.out_busy) begin
          ctl.emit1 = 1'b1;
          if (!sts.t_has2) begin
            ctl.tick_apply = 1'b1; ctl.scan_step = !sts.last_slot;
            ctl.tick_end = sts.last_slot; ctl.mark_last = sts.final_slot;
          end
        end
      ucct_pkg::ST_TEMIT2: if (!sts.out_busy) begin
        ctl.emit2 = 1'b1; ctl.tick_apply = 1'b1; ctl.scan_step = !sts.last_slot;
        ctl.tick_end = sts.last_slot; ctl.mark_last = sts.final_slot;
      end
      default: ;
    endcase
  end

  a_ready: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> in_ready) else $error("load while busy");
  a_emit_one: assert property (@(posedge clk) disable iff (rst)
    !(ctl.emit1 && ctl.emit2)) else $error("double emit");
  a_tick_end: assert property (@(posedge clk) disable iff (rst)
    ctl.tick_end |=> state == ucct_pkg::ST_IDLE) else $error("walk did not end");
endmodule

// ----- verif/udp_client_connection_tracker_test.sv -----
// Self-checking testbench for udp_client_connection_tracker: drives header and tick
// beats, predicts every result beat in a small scoreboard class. Depends on ucct_pkg.
`timescale 1ns / 1ps
module udp_client_connection_tracker_test;
  import ucct_pkg::*;

  localparam int SLOTS = 16;
  localparam int POOL = 20;
  localparam int DRAIN = 80;
  localparam int LIMIT = 600000;
  localparam logic [2:0] CMD_INVALID = 3'd4;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] seq;
    logic [31:0] echo;
    logic [31:0] acked;
    logic [15:0] cnt;
  } header_t;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  id;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] first;
    logic [31:0] lastidx;
    logic [15:0] rtt;
    logic        last;
  } result_t;

  class tracker_scoreboard;
    logic [4:0]  max_clients = 5'd16;
    logic [15:0] timeout = 16'd60;
    bit          used[SLOTS];
    logic [31:0] addr[SLOTS];
    logic [15:0] port[SLOTS];
    logic [1:0]  link[SLOTS];
    logic [15:0] idle[SLOTS];
    logic [31:0] cseq[SLOTS];
    logic [15:0] crtt[SLOTS];
    logic [31:0] latest[SLOTS];
    logic [31:0] server_seq = 0;
    logic [31:0] now = 0;
    result_t     awaited[$];
    int          errors = 0;

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int lookup(logic [31:0] a, logic [15:0] p);
      for (int s = 0; s < SLOTS; s++)
        if (used[s] && addr[s] == a && port[s] == p) return s;
      return -1;
    endfunction

    function void push(logic [2:0] k, logic [7:0] id, logic [31:0] a, logic [15:0] p,
                       logic [31:0] f, logic [31:0] l, logic [15:0] r);
      result_t e;
      e.kind = k; e.id = id; e.addr = a; e.port = p;
      e.first = f; e.lastidx = l; e.rtt = r; e.last = 1'b0;
      awaited.push_back(e);
    endfunction

    function void push_slot(int s, logic [2:0] k, logic [31:0] f, logic [31:0] l,
                            logic [15:0] r);
      push(k, s[7:0], addr[s], port[s], f, l, r);
    endfunction

    function void note_header(header_t h);
      int s;
      int start_count;
      int cap;
      int busy;
      logic [31:0] lidx;
      logic [31:0] first;
      logic [31:0] rtt;
      start_count = awaited.size();
      s = lookup(h.addr, h.port);
      case (h.cmd)
        CMD_CONNECT: begin
          cap = (max_clients < SLOTS) ? max_clients : SLOTS;
          busy = 0;
          foreach (used[i]) if (used[i]) busy++;
          if (s < 0) begin
            if (busy >= cap) begin
              push(K_REJECT, NO_CLIENT, h.addr, h.port, '0, '0, '0);
            end else begin
              s = 0;
              while (used[s]) s++;
              used[s] = 1; addr[s] = h.addr; port[s] = h.port; link[s] = LS_ACCEPTING;
              idle[s] = '0; cseq[s] = '0; crtt[s] = '0; latest[s] = '0;
            end
          end
        end
        CMD_STATE: begin
          if (s >= 0 && link[s] != LS_DISCONNECTING) begin
            if (link[s] == LS_ACCEPTING) begin
              link[s] = LS_CONNECTED;
              push_slot(s, K_CONNECTED, '0, '0, '0);
            end
            if (cseq[s] < h.seq) begin
              rtt = now - h.echo;
              if (rtt > timeout) rtt = 32'(timeout);
              cseq[s] = h.seq; crtt[s] = rtt[15:0]; idle[s] = '0;
              push_slot(s, K_STATE, h.acked, latest[s], rtt[15:0]);
            end
          end
        end
        CMD_RELIABLE: begin
          if (s >= 0 && link[s] == LS_CONNECTED) begin
            lidx = h.seq + {16'd0, h.cnt} - 32'd1;
            if (lidx > latest[s]) begin
              first = (latest[s] + 32'd1 > h.seq) ? latest[s] + 32'd1 : h.seq;
              latest[s] = lidx;
              if (h.cnt != 0 && first <= lidx) push_slot(s, K_RANGE, first, lidx, '0);
            end
          end
        end
        CMD_DISCONNECT: begin
          if (s >= 0 && link[s] != LS_DISCONNECTING) begin
            push_slot(s, K_DISCONNECTED, '0, '0, '0);
            link[s] = LS_DISCONNECTING;
            idle[s] = '0;
          end
        end
        CMD_TICK: begin
          now++;
          for (int i = 0; i < SLOTS; i++) begin
            if (!used[i]) continue;
            if (idle[i] != 16'hFFFF) idle[i]++;
            if (idle[i] >= timeout) begin
              push_slot(i, K_SEND_DISC, '0, '0, '0);
              if (link[i] != LS_DISCONNECTING) push_slot(i, K_DISCONNECTED, '0, '0, '0);
              used[i] = 0;
            end else if (link[i] == LS_DISCONNECTING) begin
              push_slot(i, K_SEND_DISC, '0, '0, '0);
            end else if (link[i] == LS_ACCEPTING) begin
              push_slot(i, K_SEND_ACCEPT, '0, '0, '0);
            end else begin
              push_slot(i, K_SEND_STATE, server_seq, latest[i], crtt[i]);
            end
          end
          server_seq++;
        end
        default: ;
      endcase
      if (awaited.size() > start_count) awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    task check(result_t got);
      result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected beat kind %0d id %0d", got.kind, got.id));
      end else begin
        e = awaited.pop_front();
        if (got.kind != e.kind) report($sformatf("kind %0d, want %0d", got.kind, e.kind));
        if (got.id != e.id) report($sformatf("client_id %0d, want %0d", got.id, e.id));
        if (got.addr != e.addr) report($sformatf("dest_addr %h, want %h", got.addr, e.addr));
        if (got.port != e.port) report($sformatf("dest_port %h, want %h", got.port, e.port));
        if (got.first != e.first)
          report($sformatf("index_first %h, want %h", got.first, e.first));
        if (got.lastidx != e.lastidx)
          report($sformatf("index_last %h, want %h", got.lastidx, e.lastidx));
        if (got.rtt != e.rtt) report($sformatf("rtt_ticks %0d, want %0d", got.rtt, e.rtt));
        if (got.last != e.last) report($sformatf("tlast %0b, want %0b", got.last, e.last));
      end
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [15:0]  cfg_data = '0;

  tracker_scoreboard sb = new();
  bit          calm = 0;
  int          cycles = 0;
  logic [31:0] pool_addr[POOL];
  logic [15:0] pool_port[POOL];
  logic [31:0] seq_hint[POOL];
  logic [31:0] rel_hint[POOL];

  udp_client_connection_tracker #(.MAX_CLIENTS(SLOTS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_t got;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    m_axis_tready <= calm || ($urandom_range(99) >= 33);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tdata[2:0];
      got.id = m_axis_tdata[10:3];
      got.addr = m_axis_tdata[42:11];
      got.port = m_axis_tdata[58:43];
      got.first = m_axis_tdata[90:59];
      got.lastidx = m_axis_tdata[122:91];
      got.rtt = m_axis_tdata[138:123];
      got.last = m_axis_tlast;
      sb.check(got);
    end
  end

  task send_header(header_t h);
    while (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, h.cnt, h.acked, h.echo, h.seq, h.port, h.addr, h.cmd};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_header(h);
  endtask

  task settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_CLIENTS) sb.max_clients = value[4:0];
    else sb.timeout = value;
  endtask

  function header_t peer_header(logic [2:0] cmd, int p);
    header_t h;
    h.cmd = cmd; h.addr = pool_addr[p]; h.port = pool_port[p];
    h.seq = 0; h.echo = 0; h.acked = 0; h.cnt = 0;
    return h;
  endfunction

  function header_t random_header();
    header_t h;
    int p;
    int pick;
    p = $urandom_range(POOL - 1);
    pick = $urandom_range(99);
    if (pick < 20) h = peer_header(CMD_CONNECT, p);
    else if (pick < 45) h = peer_header(CMD_STATE, p);
    else if (pick < 65) h = peer_header(CMD_RELIABLE, p);
    else if (pick < 72) h = peer_header(CMD_DISCONNECT, p);
    else if (pick < 77) h = peer_header($urandom_range(1) ? CMD_INVALID
                                        : ($urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7), p);
    else h = peer_header(CMD_TICK, p);
    // stranger packets from addresses outside the pool
    if ($urandom_range(9) == 0) begin
      h.addr = $urandom();
      h.port = 16'($urandom_range(16'hFFFF));
    end
    h.acked = $urandom();
    if (h.cmd == CMD_STATE) begin
      if ($urandom_range(7) == 0) h.seq = $urandom();
      else h.seq = seq_hint[p] + $urandom_range(5);
      seq_hint[p] = h.seq;
      h.echo = ($urandom_range(5) == 0) ? $urandom() : sb.now - $urandom_range(20);
    end else if (h.cmd == CMD_RELIABLE) begin
      h.seq = rel_hint[p] + 1 - $urandom_range(3);
      h.cnt = 16'($urandom_range(6));
      if ($urandom_range(9) == 0) begin
        h.seq = $urandom();
        h.cnt = 16'($urandom_range(16'hFFFF));
      end
      rel_hint[p] = h.seq + h.cnt - 1;
    end else begin
      h.seq = $urandom();
      h.echo = $urandom();
      h.cnt = 16'($urandom_range(16'hFFFF));
    end
    return h;
  endfunction

  task random_run(int count);
    for (int i = 0; i < count; i++) send_header(random_header());
  endtask

  initial begin
    header_t h;
    foreach (pool_addr[i]) begin
      pool_addr[i] = $urandom();
      pool_port[i] = 16'($urandom_range(16'hFFFF));
      seq_hint[i] = 0;
      rel_hint[i] = 0;
    end
    pool_addr[1] = 32'hFFFFFFFF; pool_port[1] = 16'hFFFF;
    pool_addr[2] = 32'h0;        pool_port[2] = 16'h0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults in force (16 clients, timeout 60)
    send_header(peer_header(CMD_CONNECT, 0));
    send_header(peer_header(CMD_CONNECT, 0));    // known peer, ignored
    send_header(peer_header(CMD_TICK, 0));       // send accept
    h = peer_header(CMD_STATE, 0); h.seq = 5; h.acked = 32'hFFFFFFFF;
    send_header(h);                              // promote + state, rtt 1
    send_header(h);                              // stale index
    h.seq = 6; h.echo = 32'hFFFFFFFF;
    send_header(h);                              // stamp from the future wraps around to rtt 2
    h = peer_header(CMD_RELIABLE, 0); h.seq = 1; h.cnt = 3;
    send_header(h);
    h.seq = 2; h.cnt = 4;
    send_header(h);                              // overlapping range
    h.seq = 10; h.cnt = 0;
    send_header(h);                              // empty buffer, end recorded
    send_header(peer_header(CMD_CONNECT, 1));
    h = peer_header(CMD_STATE, 1); h.seq = 32'hFFFFFFFF;
    send_header(h);
    h = peer_header(CMD_RELIABLE, 1); h.seq = 32'hFFFFFFFF; h.cnt = 3;
    send_header(h);                              // wrapping range
    h.seq = 5; h.cnt = 16'hFFFF;
    send_header(h);
    send_header(peer_header(CMD_STATE, 5));      // unknown peer
    send_header(peer_header(CMD_INVALID, 0));
    send_header(peer_header(CMD_SPARE6, 0));
    send_header(peer_header(CMD_SPARE7, 0));
    send_header(peer_header(CMD_CONNECT, 2));
    send_header(peer_header(CMD_RELIABLE, 2));   // accepting client, no range
    send_header(peer_header(CMD_DISCONNECT, 1));
    send_header(peer_header(CMD_DISCONNECT, 1)); // repeated
    send_header(peer_header(CMD_STATE, 1));      // disconnecting, ignored
    send_header(peer_header(CMD_TICK, 0));
    random_run(45);

    settle();
    write_reg(CFG_MAX_CLIENTS, 16'd3);           // below clients in use
    write_reg(CFG_TIMEOUT, 16'd5);
    random_run(45);

    settle();
    calm = 1;
    write_reg(CFG_MAX_CLIENTS, 16'd0);
    write_reg(CFG_TIMEOUT, 16'd1);
    random_run(45);
    calm = 0;

    settle();
    write_reg(CFG_MAX_CLIENTS, 16'd31);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    random_run(45);

    settle();
    write_reg(CFG_MAX_CLIENTS, 16'd1);
    write_reg(CFG_TIMEOUT, 16'd8);
    random_run(45);

    settle();
    write_reg(CFG_MAX_CLIENTS, 16'd16);
    write_reg(CFG_TIMEOUT, 16'd12);
    random_run(45);

    settle();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/ucct_pkg.sv
hw/rtl/ucct_datapath.sv
hw/rtl/ucct_ctrl.sv
hw/rtl/udp_client_connection_tracker.sv
verif/udp_client_connection_tracker_test.sv
